### hw/rtl/base64_url_decoder_unit_defines.svh
// Assertion macros for the base64url decoder.
`ifndef BASE64_URL_DECODER_UNIT_DEFINES_SVH
`define BASE64_URL_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [5:0] SEXTET_DASH = 6'd62;
  localparam logic [5:0] SEXTET_UNDS = 6'd63;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  // One queue entry: everything a single character produces.
  typedef struct packed {
    logic [2:0][7:0] data;    // decoded bytes, entry 0 goes out first
    logic [1:0]      nbytes;  // 0..3 bytes valid
    logic            is_end;  // status item follows the bytes
    logic            fail;
    logic [7:0]      count;
  } b64d_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  // bit 6 set: not part of the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == CHAR_DASH) r = {1'b0, SEXTET_DASH};
    else if (c == 8'h5F) r = {1'b0, SEXTET_UNDS};
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/b64d_front.sv
`default_nettype none
module b64d_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_char,
  input  wire logic              last_char,
  input  wire b64d_pkg::b64d_qstat_t q_stat,
  output logic                   push,
  output b64d_pkg::b64d_job_t    push_job
);
  import b64d_pkg::*;

  localparam logic [1:0] MSG_FIRST  = 2'd0;
  localparam logic [1:0] MSG_SECOND = 2'd1;
  localparam logic [1:0] MSG_LATER  = 2'd2;

  logic [1:0]  msg_pos, msg_pos_next;
  logic        held_dash, held_dash_next;
  logic [1:0]  grp_pos, grp_pos_next;
  logic [17:0] sextets, sextets_next;
  logic        third_pad, third_pad_next;
  logic        stopped, stopped_next;
  logic        err_seen, err_seen_next;
  logic [7:0]  dec_count, dec_count_next;

  logic        accept;
  logic        do_feed;
  logic [6:0]  sx;
  logic        bad;
  logic        pad4;
  logic [1:0]  nb;
  logic [8:0]  sum;
  logic        fail;
  logic [5:0]  s1, s2, s3;

  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign sx       = sextet_of(in_char);
  assign bad      = sx[6];

  always_comb begin
    msg_pos_next   = msg_pos;
    held_dash_next = held_dash;
    grp_pos_next   = grp_pos;
    sextets_next   = sextets;
    third_pad_next = third_pad;
    stopped_next   = stopped;
    err_seen_next  = err_seen;
    dec_count_next = dec_count;
    do_feed        = 1'b1;
    nb             = 2'd0;
    pad4           = 1'b0;
    s1             = 6'd0;
    s2             = 6'd0;
    s3             = 6'd0;
    sum            = 9'd0;
    fail           = 1'b0;
    push_job       = '0;

    // leading "- " handling
    case (msg_pos)
      MSG_FIRST: begin
        msg_pos_next = MSG_SECOND;
        if (in_char == CHAR_DASH && !last_char) begin
          held_dash_next = 1'b1;
          do_feed        = 1'b0;
        end
      end
      MSG_SECOND: begin
        msg_pos_next = MSG_LATER;
        if (held_dash) begin
          held_dash_next = 1'b0;
          if (in_char == CHAR_SPACE) begin
            do_feed = 1'b0;
          end else begin
            // the held dash lands as first sextet of the first group
            grp_pos_next = 2'd1;
            sextets_next = {12'd0, SEXTET_DASH};
          end
        end
      end
      default: begin
        msg_pos_next = msg_pos;
      end
    endcase

    if (do_feed && !stopped_next) begin
      if (grp_pos_next == 2'd0 && in_char == CHAR_NUL && dec_count_next != 8'd0) begin
        stopped_next = 1'b1;
      end else if (grp_pos_next <= 2'd1) begin
        if (bad) begin
          err_seen_next = 1'b1;
          stopped_next  = 1'b1;
        end else begin
          sextets_next = {sextets_next[11:0], sx[5:0]};
          grp_pos_next = grp_pos_next + 2'd1;
        end
      end else if (grp_pos_next == 2'd2) begin
        if (in_char == CHAR_PAD) begin
          third_pad_next = 1'b1;
          sextets_next   = {sextets_next[11:0], 6'd0};
          grp_pos_next   = 2'd3;
        end else if (bad) begin
          err_seen_next = 1'b1;
          stopped_next  = 1'b1;
        end else begin
          third_pad_next = 1'b0;
          sextets_next   = {sextets_next[11:0], sx[5:0]};
          grp_pos_next   = 2'd3;
        end
      end else begin
        pad4 = (in_char == CHAR_PAD);
        s1   = sextets_next[17:12];
        s2   = sextets_next[11:6];
        s3   = sextets_next[5:0];
        if (!pad4 && bad) begin
          err_seen_next = 1'b1;
          stopped_next  = 1'b1;
        end else begin
          push_job.data[0] = {s1, s2[5:4]};
          push_job.data[1] = {s2[3:0], s3[5:2]};
          push_job.data[2] = {s3[1:0], sx[5:0]};
          nb = third_pad_next ? 2'd1 : (pad4 ? 2'd2 : 2'd3);
          sum = {1'b0, dec_count_next} + {7'd0, nb};
          dec_count_next = sum[8] ? COUNT_MAX : sum[7:0];
          grp_pos_next   = 2'd0;
          sextets_next   = '0;
          third_pad_next = 1'b0;
          if (pad4) stopped_next = 1'b1;
        end
      end
    end

    push_job.nbytes = nb;
    push_job.is_end = last_char;
    if (last_char) begin
      fail = err_seen_next | (~stopped_next & (grp_pos_next != 2'd0));
      push_job.fail  = fail;
      push_job.count = fail ? 8'd0 : dec_count_next;
      // message finished: back to reset state
      msg_pos_next   = MSG_FIRST;
      held_dash_next = 1'b0;
      grp_pos_next   = 2'd0;
      sextets_next   = '0;
      third_pad_next = 1'b0;
      stopped_next   = 1'b0;
      err_seen_next  = 1'b0;
      dec_count_next = 8'd0;
    end
  end

  assign push = accept & ((nb != 2'd0) | last_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_pos   <= MSG_FIRST;
      held_dash <= 1'b0;
      grp_pos   <= 2'd0;
      sextets   <= '0;
      third_pad <= 1'b0;
      stopped   <= 1'b0;
      err_seen  <= 1'b0;
      dec_count <= 8'd0;
    end else if (accept) begin
      msg_pos   <= msg_pos_next;
      held_dash <= held_dash_next;
      grp_pos   <= grp_pos_next;
      sextets   <= sextets_next;
      third_pad <= third_pad_next;
      stopped   <= stopped_next;
      err_seen  <= err_seen_next;
      dec_count <= dec_count_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/b64d_queue.sv
`default_nettype none
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire b64d_pkg::b64d_job_t  push_job,
  input  wire logic                 pop,
  output b64d_pkg::b64d_job_t       head,
  output b64d_pkg::b64d_qstat_t     q_stat
);
  import b64d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_job_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push = push & ~q_stat.full;
  assign do_pop  = pop & ~q_stat.empty;
  assign head    = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/b64d_back.sv
`default_nettype none
module b64d_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire b64d_pkg::b64d_job_t   head,
  input  wire b64d_pkg::b64d_qstat_t q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       has_byte,
  output logic                       run_last,
  output logic                       message_done,
  output logic                       failed,
  output logic [7:0]                 byte_count
);
  import b64d_pkg::*;

  b64d_job_t  cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [2:0] total;
  logic       take, job_done;

  assign total    = {1'b0, cur.nbytes} + {2'b00, cur.is_end};
  assign run_last = ({1'b0, idx} == (total - 3'd1));
  assign take     = out_valid & ~out_stall;
  assign job_done = take & run_last;
  assign pop      = ~q_stat.empty & (~cur_valid | job_done);

  assign out_valid    = cur_valid;
  assign has_byte     = (idx < cur.nbytes);
  assign out_byte     = has_byte ? cur.data[idx] : 8'd0;
  assign message_done = ~has_byte;
  assign failed       = message_done & cur.fail;
  assign byte_count   = message_done ? cur.count : 8'd0;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (job_done) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/base64_url_decoder_unit.sv
// A character's first result is registered into the job queue, then into the output register.
// Throughput: one character per cycle unless the job queue is full; the output moves one result
//   per cycle while out_stall is low; a character yields up to four results (3 bytes + end status).
// The front stalls only when the job queue is full; the queue depth sets how long a burst lasts.
// Reset (rst, synchronous, active high): message state, queue and output stage empty.
`default_nettype none
`include "base64_url_decoder_unit_defines.svh"
module base64_url_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // character input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       last_char,
  // result output
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            run_last,
  output logic            message_done,
  output logic            failed,
  output logic [7:0]      byte_count
);
  import b64d_pkg::*;

  b64d_job_t   push_job;
  b64d_job_t   head;
  b64d_qstat_t q_stat;
  logic        push;
  logic        pop;

  // Front: keeps the whole message state and turns each character transfer into
  // one job (0-3 bytes plus optional end status). Characters that produce
  // nothing push nothing.
  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .last_char (last_char),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Short job queue so front and back stall independently.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: holds one job in the output register and walks its results,
  // one transfer per cycle while out_stall is low, refilling from the queue on the last one.
  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .run_last     (run_last),
    .message_done (message_done),
    .failed       (failed),
    .byte_count   (byte_count)
  );

  // status item always closes the run of its character
  `B64D_ASSERT_NOW(a_done_is_last, out_valid && message_done, run_last, "end item not last of run")
  // a failed message reports no count
  `B64D_ASSERT_NOW(a_fail_no_count, out_valid && failed, byte_count == 8'd0, "failed with nonzero count")
  // front never pushes into a full queue
  `B64D_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "push into full queue")
  // a stalled result stays on the port
  `B64D_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(message_done), "stalled result changed")

endmodule
`default_nettype wire
